### src/srv_pkg.sv
`default_nettype none
package srv_pkg;

	localparam int unsigned REC_SIZE = 48;
	localparam int unsigned CRC_END  = 44;
	localparam int unsigned ID_START = 13;
	localparam int unsigned GEN_START = 8;
	localparam int unsigned ID_LEN_POS = 12;
	localparam int unsigned CNT_SAT  = 49;
	localparam logic [31:0] CRC_POLY = 32'hedb88320;
	localparam logic [31:0] CRC_INIT = 32'hffffffff;
	localparam logic [7:0] MAGIC [4] = '{8'h50, 8'h4d, 8'h41, 8'h53};
	localparam logic [7:0] VERSION_MAJOR = 8'd1;

	typedef enum logic [3:0] {
		ST_OK       = 4'd0,
		ST_LENGTH   = 4'd1,
		ST_MAGIC    = 4'd2,
		ST_VERSION  = 4'd3,
		ST_SIZE     = 4'd4,
		ST_CRC      = 4'd5,
		ST_ZERO_GEN = 4'd6,
		ST_ID_LEN   = 4'd7,
		ST_PADDING  = 4'd8,
		ST_ID_CHAR  = 4'd9
	} status_t;

	typedef enum logic [1:0] {
		TX_IDLE,
		TX_READ,
		TX_SHOW
	} tx_state_t;

	typedef struct packed {
		logic        start;
		status_t     status;
		logic [31:0] generation;
		logic [4:0]  id_len;
	} rec_sum_t;

	typedef struct packed {
		logic       en;
		logic [4:0] idx;
		logic [7:0] data;
	} id_wr_t;

	typedef struct packed {
		logic       en;
		logic [4:0] idx;
	} id_rd_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

	function automatic logic id_char_ok(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h30 && c <= 8'h39) ||
			c == 8'h5f || c == 8'h2d;
	endfunction

	function automatic status_t err_min(input status_t a, input status_t b);
		if (a == ST_OK) begin
			return b;
		end
		if (b == ST_OK) begin
			return a;
		end
		return (b < a) ? b : a;
	endfunction

endpackage
`default_nettype wire

### src/srv_in_if.sv
`default_nettype none
interface srv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

### src/srv_out_if.sv
`default_nettype none
interface srv_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic [31:0] generation;
	logic [4:0]  id_size;
	logic [7:0]  id_char;
	logic [4:0]  id_index;
	logic        last_result;

	modport source (output valid, output status, output generation, output id_size,
		output id_char, output id_index, output last_result, input ready);
	modport sink (input valid, input status, input generation, input id_size,
		input id_char, input id_index, input last_result, output ready);
endinterface
`default_nettype wire

### src/srv_idmem.sv
`default_nettype none
module srv_idmem #(
	parameter int DEPTH = 31
) (
	input  wire logic           clk,
	input  wire srv_pkg::id_wr_t wr,
	input  wire srv_pkg::id_rd_t rd,
	output logic [7:0]          rdata
);
	import srv_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx[AW-1:0]] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rdata <= mem[rd.idx[AW-1:0]];
		end
	end
endmodule
`default_nettype wire

### src/srv_rx.sv
`default_nettype none
module srv_rx #(
	parameter int ID_CAPACITY = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	srv_in_if.sink                in_ch,
	input  wire logic             busy,
	output srv_pkg::rec_sum_t     sum,
	output srv_pkg::id_wr_t       wr
);
	import srv_pkg::*;

	localparam int DEPTH = ID_CAPACITY - 1;

	logic [5:0]  cnt_q, cnt_d;
	logic [31:0] crc_q, crc_d;
	status_t     fe_q, fe_d, err, fin;
	logic [31:0] gen_q, gen_d;
	logic [7:0]  len_q, len_d;
	logic        zero_q, zero_d;
	logic [4:0]  n_q, n_d;
	logic [4:0]  idx;
	logic [31:0] crc_exp;
	logic        acc;
	logic [7:0]  b;

	assign in_ch.ready = !busy;
	assign acc = in_ch.valid && !busy;
	assign b = in_ch.data_byte;
	assign idx = 5'(cnt_q - 6'(ID_START));
	assign crc_exp = (~crc_q) >> {cnt_q[1:0], 3'b000};

	always_comb begin
		err = ST_OK;
		crc_d = crc_q;
		gen_d = gen_q;
		len_d = len_q;
		zero_d = zero_q;
		n_d = n_q;
		wr = '0;
		wr.idx = idx;
		wr.data = b;
		if (cnt_q < 6'(CRC_END)) begin
			crc_d = crc_byte(crc_q, b);
		end
		if (cnt_q < 6'd4) begin
			if (b != MAGIC[cnt_q[1:0]]) err = ST_MAGIC;
		end else if (cnt_q == 6'd4) begin
			if (b != VERSION_MAJOR) err = ST_VERSION;
		end else if (cnt_q == 6'd5) begin
			if (b != 8'd0) err = ST_VERSION;
		end else if (cnt_q == 6'd6) begin
			if (b != 8'(REC_SIZE)) err = ST_SIZE;
		end else if (cnt_q == 6'd7) begin
			if (b != 8'd0) err = ST_SIZE;
		end else if (cnt_q < 6'(ID_LEN_POS)) begin
			gen_d[{cnt_q[1:0], 3'b000} +: 8] = b;
		end else if (cnt_q == 6'(ID_LEN_POS)) begin
			len_d = b;
			if (b == 8'd0 || b >= 8'(ID_CAPACITY)) err = ST_ID_LEN;
		end else if (cnt_q < 6'(CRC_END)) begin
			if ({3'b000, idx} < len_q) begin
				wr.en = acc && (idx < 5'(DEPTH));
				if (!zero_q) begin
					if (b == 8'd0) begin
						zero_d = 1'b1;
						if (idx == 5'd0) err = ST_ID_CHAR;
					end else begin
						n_d = n_q + 5'd1;
						if (!id_char_ok(b)) err = ST_ID_CHAR;
					end
				end
			end else if (b != 8'd0) begin
				err = ST_PADDING;
			end
		end else if (cnt_q < 6'(REC_SIZE)) begin
			if (b != crc_exp[7:0]) err = ST_CRC;
		end
		fe_d = err_min(fe_q, err);
		cnt_d = (cnt_q == 6'(CNT_SAT)) ? cnt_q : cnt_q + 6'd1;
		fin = err_min(fe_d, (cnt_d != 6'(REC_SIZE)) ? ST_LENGTH : ST_OK);
		fin = err_min(fin, (gen_d == 32'd0) ? ST_ZERO_GEN : ST_OK);
	end

	always_comb begin
		sum.start = acc && in_ch.last_byte;
		sum.status = fin;
		sum.generation = gen_d;
		sum.id_len = n_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			crc_q <= CRC_INIT;
			fe_q <= ST_OK;
			gen_q <= '0;
			len_q <= '0;
			zero_q <= 1'b0;
			n_q <= '0;
		end else if (acc) begin
			if (in_ch.last_byte) begin
				cnt_q <= '0;
				crc_q <= CRC_INIT;
				fe_q <= ST_OK;
				gen_q <= '0;
				len_q <= '0;
				zero_q <= 1'b0;
				n_q <= '0;
			end else begin
				cnt_q <= cnt_d;
				crc_q <= crc_d;
				fe_q <= fe_d;
				gen_q <= gen_d;
				len_q <= len_d;
				zero_q <= zero_d;
				n_q <= n_d;
			end
		end
	end
endmodule
`default_nettype wire

### src/srv_tx.sv
`default_nettype none
module srv_tx (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire srv_pkg::rec_sum_t sum,
	output srv_pkg::id_rd_t        rd,
	input  wire logic [7:0]        rdata,
	srv_out_if.source              out_ch,
	output logic                   busy
);
	import srv_pkg::*;

	tx_state_t   state_q, state_d;
	status_t     status_q;
	logic [31:0] gen_q;
	logic [4:0]  n_q;
	logic [4:0]  k_q;
	logic        is_last;

	assign is_last = (status_q != ST_OK) || (5'(k_q + 5'd1) == n_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			TX_IDLE: begin
				if (sum.start) begin
					state_d = (sum.status == ST_OK) ? TX_READ : TX_SHOW;
				end
			end
			TX_READ: state_d = TX_SHOW;
			TX_SHOW: begin
				if (out_ch.ready) begin
					state_d = is_last ? TX_IDLE : TX_READ;
				end
			end
			default: state_d = TX_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != TX_IDLE);
		rd.en = (state_q == TX_READ);
		rd.idx = k_q;
		out_ch.valid = (state_q == TX_SHOW);
		out_ch.status = status_q;
		out_ch.generation = gen_q;
		out_ch.id_size = n_q;
		out_ch.id_char = (status_q == ST_OK) ? rdata : 8'd0;
		out_ch.id_index = k_q;
		out_ch.last_result = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TX_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == TX_IDLE && sum.start) begin
			status_q <= sum.status;
			k_q <= '0;
			if (sum.status == ST_OK) begin
				gen_q <= sum.generation;
				n_q <= sum.id_len;
			end else begin
				gen_q <= '0;
				n_q <= '0;
			end
		end else if (state_q == TX_SHOW && out_ch.ready && !is_last) begin
			k_q <= k_q + 5'd1;
		end
	end
endmodule
`default_nettype wire

### src/selection_record_validator_top.sv
// channel  dir  request fields
// in_ch    in   data_byte, last_byte
// out_ch   out  status, generation, id_size, id_char, id_index, last_result
//
// one byte per cycle is taken while no results are pending
// after the last byte of a good record, each result is read from the id memory, then shown until taken
// a failing record gives a single result, shown in the cycle after its last byte
// input is held off until the final result of a record is taken
// arst_n clears the record state; the id memory is not cleared
`default_nettype none
module selection_record_validator_top #(
	parameter int ID_CAPACITY = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	srv_in_if.sink    in_ch,
	srv_out_if.source out_ch
);
	import srv_pkg::*;

	rec_sum_t   sum;
	id_wr_t     wr;
	id_rd_t     rd;
	logic [7:0] rdata;
	logic       busy;

	srv_rx #(.ID_CAPACITY(ID_CAPACITY)) u_rx (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.busy   (busy),
		.sum    (sum),
		.wr     (wr)
	);

	srv_idmem #(.DEPTH(ID_CAPACITY - 1)) u_mem (
		.clk   (clk),
		.wr    (wr),
		.rd    (rd),
		.rdata (rdata)
	);

	srv_tx u_tx (
		.clk    (clk),
		.arst_n (arst_n),
		.sum    (sum),
		.rd     (rd),
		.rdata  (rdata),
		.out_ch (out_ch),
		.busy   (busy)
	);
endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
module tb;
	import srv_pkg::*;

	localparam int unsigned ID_CAP = 32;
	localparam int unsigned ID_SLOTS = CRC_END - ID_START;
	localparam int unsigned FEED_BYTES = 280;
	localparam int unsigned IDLE_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES = 100;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} feed_t;

	typedef struct {
		status_t     status;
		logic [31:0] generation;
		logic [4:0]  id_size;
		logic [7:0]  id_char;
		logic [4:0]  id_index;
		logic        last;
	} verdict_t;

	typedef enum int {
		MUT_NONE,
		MUT_ZERO_IN_ID,
		MUT_FLIP,
		MUT_LENGTH,
		MUT_ZERO_GEN,
		MUT_BAD_LEN,
		MUT_PADDING,
		MUT_BAD_CHAR,
		MUT_CRC,
		MUT_NOISE
	} mutation_t;

	logic clk = 1'b0;
	logic arst_n;

	srv_in_if in_ch();
	srv_out_if out_ch();

	selection_record_validator_top #(
		.ID_CAPACITY(ID_CAP)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	feed_t byte_feed_q[$];
	verdict_t verdict_q[$];
	logic [7:0] rec_img [REC_SIZE];
	int unsigned byte_total;
	int unsigned bytes_taken;
	int unsigned fail_count;

	// record tracking state of the predictor
	int unsigned rec_pos;
	logic [31:0] rec_crc;
	status_t rec_fault;
	logic [31:0] rec_gen;
	logic [7:0] rec_len;
	logic rec_zero_hit;
	logic [7:0] rec_id [ID_SLOTS];

	function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [7:0] pick_id_char();
		int unsigned r;
		r = $urandom_range(0, 37);
		if (r < 26) begin
			return 8'h61 + 8'(r);
		end
		if (r < 36) begin
			return 8'h30 + 8'(r - 26);
		end
		return (r == 36) ? 8'h5f : 8'h2d;
	endfunction

	function automatic int unsigned draw_gap(inout int unsigned stretch, inout bit calm);
		if (stretch == 0) begin
			stretch = $urandom_range(16, 64);
			calm = ($urandom_range(0, 2) == 0);
		end
		stretch--;
		return calm ? 0 : $urandom_range(0, 12);
	endfunction

	function void flag_fault(input status_t code);
		if (rec_fault == ST_OK || code < rec_fault) begin
			rec_fault = code;
		end
	endfunction

	function void clear_record();
		rec_pos = 0;
		rec_crc = CRC_INIT;
		rec_fault = ST_OK;
		rec_gen = '0;
		rec_len = '0;
		rec_zero_hit = 1'b0;
	endfunction

	function void absorb_record_byte(input logic [7:0] b, input logic last);
		int unsigned pos;
		int unsigned i;
		int unsigned n;
		logic [31:0] crc_want;
		verdict_t v;
		pos = rec_pos;
		if (pos < CRC_END) begin
			rec_crc = crc_step(rec_crc, b);
		end
		if (pos < 4) begin
			if (b != MAGIC[pos]) begin
				flag_fault(ST_MAGIC);
			end
		end else if (pos == 4) begin
			if (b != VERSION_MAJOR) begin
				flag_fault(ST_VERSION);
			end
		end else if (pos == 5) begin
			if (b != 8'd0) begin
				flag_fault(ST_VERSION);
			end
		end else if (pos == 6) begin
			if (b != 8'(REC_SIZE)) begin
				flag_fault(ST_SIZE);
			end
		end else if (pos == 7) begin
			if (b != 8'd0) begin
				flag_fault(ST_SIZE);
			end
		end else if (pos < ID_LEN_POS) begin
			rec_gen |= 32'(b) << ((pos - GEN_START) * 8);
		end else if (pos == ID_LEN_POS) begin
			rec_len = b;
			if (b == 8'd0 || b >= 8'(ID_CAP)) begin
				flag_fault(ST_ID_LEN);
			end
		end else if (pos < CRC_END) begin
			i = pos - ID_START;
			if (i < rec_len) begin
				rec_id[i] = b;
				if (!rec_zero_hit) begin
					if (b == 8'd0) begin
						rec_zero_hit = 1'b1;
						if (i == 0) begin
							flag_fault(ST_ID_CHAR);
						end
					end else if (!(b inside {[8'h61:8'h7a], [8'h30:8'h39], 8'h5f, 8'h2d})) begin
						flag_fault(ST_ID_CHAR);
					end
				end
			end else if (b != 8'd0) begin
				flag_fault(ST_PADDING);
			end
		end else if (pos < REC_SIZE) begin
			crc_want = ~rec_crc;
			if (b != crc_want[(pos - CRC_END) * 8 +: 8]) begin
				flag_fault(ST_CRC);
			end
		end
		rec_pos = (pos + 1 > CNT_SAT) ? CNT_SAT : pos + 1;
		if (!last) begin
			return;
		end
		if (rec_pos != REC_SIZE) begin
			flag_fault(ST_LENGTH);
		end
		if (rec_gen == 32'd0) begin
			flag_fault(ST_ZERO_GEN);
		end
		if (rec_fault != ST_OK) begin
			v.status = rec_fault;
			v.generation = '0;
			v.id_size = '0;
			v.id_char = '0;
			v.id_index = '0;
			v.last = 1'b1;
			verdict_q.push_back(v);
		end else begin
			n = 0;
			while (n < rec_len && n < ID_SLOTS && rec_id[n] != 8'd0) begin
				n++;
			end
			for (int unsigned k = 0; k < n; k++) begin
				v.status = ST_OK;
				v.generation = rec_gen;
				v.id_size = 5'(n);
				v.id_char = rec_id[k];
				v.id_index = 5'(k);
				v.last = (k + 1 == n);
				verdict_q.push_back(v);
			end
		end
		clear_record();
	endfunction

	function void check_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%t %s mismatch: expected %0h, got %0h", $time, what, want, got);
		end
	endfunction

	// record image helpers
	task automatic seal_crc();
		logic [31:0] c;
		c = CRC_INIT;
		for (int k = 0; k < CRC_END; k++) begin
			c = crc_step(c, rec_img[k]);
		end
		c = ~c;
		for (int k = 0; k < 4; k++) begin
			rec_img[CRC_END + k] = c[k * 8 +: 8];
		end
	endtask

	task automatic build_record(input logic [31:0] gen_val, input int unsigned id_len);
		for (int k = 0; k < 4; k++) begin
			rec_img[k] = MAGIC[k];
			rec_img[GEN_START + k] = gen_val[k * 8 +: 8];
		end
		rec_img[4] = VERSION_MAJOR;
		rec_img[5] = 8'd0;
		rec_img[6] = 8'(REC_SIZE);
		rec_img[7] = 8'd0;
		rec_img[ID_LEN_POS] = 8'(id_len);
		for (int unsigned i = 0; i < ID_SLOTS; i++) begin
			rec_img[ID_START + i] = (i < id_len) ? pick_id_char() : 8'd0;
		end
		seal_crc();
	endtask

	task automatic send_record(input int unsigned nbytes);
		feed_t f;
		for (int unsigned k = 0; k < nbytes; k++) begin
			f.data = (k < REC_SIZE) ? rec_img[k] : 8'($urandom_range(0, 255));
			f.last = (k + 1 == nbytes);
			byte_feed_q.push_back(f);
		end
	endtask

	function automatic logic [31:0] any_gen();
		logic [31:0] g;
		g = $urandom();
		return (g == 32'd0) ? 32'd1 : g;
	endfunction

	// request driver
	int unsigned in_wait;
	int unsigned in_stretch;
	bit in_calm;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data_byte <= 8'd0;
			in_ch.last_byte <= 1'b0;
			in_wait <= 0;
		end else if (!(in_ch.valid && !in_ch.ready)) begin
			if (in_wait > 0) begin
				in_ch.valid <= 1'b0;
				in_wait <= in_wait - 1;
			end else if (byte_feed_q.size() != 0) begin
				feed_t f;
				f = byte_feed_q.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.data_byte <= f.data;
				in_ch.last_byte <= f.last;
				in_wait <= draw_gap(in_stretch, in_calm);
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// monitor and checker
	int unsigned out_wait;
	int unsigned out_stretch;
	bit out_calm;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b1;
			out_wait <= 0;
		end else begin
			int unsigned gap;
			verdict_t want;
			if (in_ch.valid && in_ch.ready) begin
				absorb_record_byte(in_ch.data_byte, in_ch.last_byte);
				bytes_taken++;
			end
			if (out_ch.valid && out_ch.ready) begin
				if (verdict_q.size() == 0) begin
					fail_count++;
					$display("%t unexpected result: expected none, got status %0d id_char %0h",
						$time, out_ch.status, out_ch.id_char);
				end else begin
					want = verdict_q.pop_front();
					check_field("status", 32'(want.status), 32'(out_ch.status));
					check_field("generation", want.generation, out_ch.generation);
					check_field("id_size", 32'(want.id_size), 32'(out_ch.id_size));
					check_field("id_char", 32'(want.id_char), 32'(out_ch.id_char));
					check_field("id_index", 32'(want.id_index), 32'(out_ch.id_index));
					check_field("last_result", 32'(want.last), 32'(out_ch.last_result));
				end
				gap = draw_gap(out_stretch, out_calm);
				if (gap > 0) begin
					out_ch.ready <= 1'b0;
					out_wait <= gap;
				end
			end else if (out_wait > 0) begin
				if (out_wait == 1) begin
					out_ch.ready <= 1'b1;
				end
				out_wait <= out_wait - 1;
			end
		end
	end

	// watchdog
	int unsigned idle_cycles;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%t timeout, %0d results outstanding", $time, verdict_q.size());
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int unsigned fed_bytes;
		int unsigned n;
		int unsigned id_len;
		mutation_t kind;
		arst_n = 1'b0;
		fail_count = 0;
		bytes_taken = 0;
		clear_record();

		// directed records
		build_record(32'd1, 1);
		send_record(REC_SIZE);
		build_record(32'hffffffff, 31);
		send_record(REC_SIZE);
		build_record(any_gen(), 10);
		rec_img[ID_START + 4] = 8'd0;
		rec_img[ID_START + 7] = 8'hff;
		seal_crc();
		send_record(REC_SIZE);
		// magic and crc both wrong, the lower code wins
		build_record(any_gen(), 4);
		rec_img[2] = "X";
		send_record(REC_SIZE);
		build_record(any_gen(), 4);
		send_record(1);

		// random records, some well formed and the rest mutated
		fed_bytes = byte_feed_q.size();
		while (fed_bytes < FEED_BYTES) begin
			id_len = $urandom_range(1, ID_SLOTS);
			n = $urandom_range(0, 17);
			kind = (n < 8) ? MUT_NONE : mutation_t'(n - 8);
			build_record(any_gen(), id_len);
			n = REC_SIZE;
			case (kind)
				MUT_ZERO_IN_ID: begin
					rec_img[ID_START + $urandom_range(0, id_len - 1)] = 8'd0;
					seal_crc();
				end
				MUT_FLIP: begin
					rec_img[$urandom_range(0, REC_SIZE - 1)] ^= 8'h01 << $urandom_range(0, 7);
					if ($urandom_range(0, 1) == 1) begin
						seal_crc();
					end
				end
				MUT_LENGTH: begin
					n = ($urandom_range(0, 1) == 1) ? $urandom_range(1, REC_SIZE - 1) :
						$urandom_range(REC_SIZE + 1, REC_SIZE + 12);
				end
				MUT_ZERO_GEN: begin
					for (int k = 0; k < 4; k++) begin
						rec_img[GEN_START + k] = 8'd0;
					end
					seal_crc();
				end
				MUT_BAD_LEN: begin
					rec_img[ID_LEN_POS] = ($urandom_range(0, 1) == 1) ? 8'd0 :
						8'($urandom_range(ID_CAP, 255));
					seal_crc();
				end
				MUT_PADDING: begin
					if (id_len < ID_SLOTS) begin
						rec_img[ID_START + $urandom_range(id_len, ID_SLOTS - 1)] =
							8'($urandom_range(1, 255));
						seal_crc();
					end
				end
				MUT_BAD_CHAR: begin
					rec_img[ID_START + $urandom_range(0, id_len - 1)] =
						($urandom_range(0, 1) == 1) ? (8'h80 | 8'($urandom_range(0, 127))) :
						(8'h41 + 8'($urandom_range(0, 25)));
					seal_crc();
				end
				MUT_CRC: begin
					rec_img[$urandom_range(CRC_END, REC_SIZE - 1)] ^= 8'h01 << $urandom_range(0, 7);
				end
				MUT_NOISE: begin
					for (int k = 0; k < REC_SIZE; k++) begin
						rec_img[k] = 8'($urandom_range(0, 255));
					end
					n = $urandom_range(1, REC_SIZE + 8);
				end
				default: begin
				end
			endcase
			fed_bytes += n;
			send_record(n);
		end
		byte_total = byte_feed_q.size();

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (bytes_taken < byte_total || verdict_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
